/* sv/assert_macros.svh */
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, skipped while in reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// next-cycle implication, skipped while in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

/* sv/spit_pkg.sv */
`default_nettype none
package spit_pkg;

  typedef logic [15:0] thr_t;
  typedef logic [1:0]  stage_t;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_ACTIVITY = 2'd1,
    CMD_INH_ADD  = 2'd2,
    CMD_INH_DROP = 2'd3
  } cmd_t;

  // configuration register indexes
  localparam logic [1:0] REG_DIM  = 2'd0;
  localparam logic [1:0] REG_LOCK = 2'd1;
  localparam logic [1:0] REG_OFF  = 2'd2;

  // stage codes; STAGE_DONE means every stage has been passed
  localparam stage_t STAGE_DIM  = 2'd0;
  localparam stage_t STAGE_LOCK = 2'd1;
  localparam stage_t STAGE_OFF  = 2'd2;
  localparam stage_t STAGE_DONE = 2'd3;

  localparam thr_t DIM_RESET     = 16'd300;
  localparam thr_t LOCK_RESET    = 16'd600;
  localparam thr_t OFF_RESET     = 16'd900;
  localparam thr_t COUNTDOWN_MIN = 16'd1;

  typedef struct packed {
    thr_t dim;
    thr_t lock;
    thr_t off;
  } thr_set_t;

  typedef struct packed {
    logic armed;
    thr_t countdown;
  } arm_t;

  typedef struct packed {
    stage_t stage;
    logic   armed;
    thr_t   countdown;
    logic   dim_on;
    logic   power_on;
  } timer_state_t;

  typedef struct packed {
    cmd_t command;
    logic lock_held;
  } item_t;

  typedef struct packed {
    stage_t stage_now;
    logic   dim_active;
    logic   outputs_on;
    logic   lock_request;
    logic   inhibited;
    logic   timer_running;
  } result_t;

  // countdown load: next enabled threshold minus the largest one already passed
  function automatic arm_t arm_calc(stage_t stage, thr_set_t thr, logic inh_live);
    thr_t next_thr;
    thr_t passed;
    thr_t delay;
    arm_t r;
    if (stage == STAGE_DIM && thr.dim != '0) begin
      next_thr = thr.dim;
    end else if (stage <= STAGE_LOCK && thr.lock != '0) begin
      next_thr = thr.lock;
    end else if (stage <= STAGE_OFF && thr.off != '0) begin
      next_thr = thr.off;
    end else begin
      next_thr = '0;
    end
    passed = '0;
    if (stage >= STAGE_LOCK) begin
      passed = thr.dim;
    end
    if (stage >= STAGE_OFF && thr.lock > passed) begin
      passed = thr.lock;
    end
    if (stage >= STAGE_DONE && thr.off > passed) begin
      passed = thr.off;
    end
    delay = (next_thr > passed) ? next_thr - passed : '0;
    if (delay < COUNTDOWN_MIN) begin
      delay = COUNTDOWN_MIN;
    end
    r.armed     = (next_thr != '0) && !inh_live;
    r.countdown = r.armed ? delay : '0;
    return r;
  endfunction

endpackage
`default_nettype wire

/* sv/staged_idle_power_timer_core.sv */
// Staged inactivity timer: dim, lock request, then display power off.
// Item channel: item_valid / item_stall carry command (tick, activity,
// inhibitor added, inhibitor removed) and lock_held. Result channel:
// result_valid / result_stall carry the stage reached, dim, power, a
// one-result lock request pulse, inhibit status and countdown status.
// Each accepted transaction gives exactly one result.
// An accepted item is captured in the input register, and its result is then
// captured in the result register, which raises result_valid.
// Throughput is one item per cycle while result_stall is low, set by the single
// next-state update between the input register and the result register.
// When the receiver stalls, the result register holds and the input
// register still takes one more item; after that item_stall follows
// result_stall.
// Configuration: cfg_wr_en, cfg_index, cfg_data write the dim, lock and off
// thresholds (index 0..2) and re-arm the countdown; other indexes are
// ignored. Write only while no transaction is in flight.
// Reset (rst, synchronous): thresholds 300/600/900, stage 0, power on,
// countdown armed with the dim threshold, no result pending.
`default_nettype none
module staged_idle_power_timer_core
  import spit_pkg::*;
#(
  parameter int INHIBIT_COUNT_MAX = 255
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic [1:0]  command,
  input  wire logic        lock_held,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [1:0]       stage_now,
  output logic             dim_active,
  output logic             outputs_on,
  output logic             lock_request,
  output logic             inhibited,
  output logic             timer_running
);

  localparam int INH_W = $clog2(INHIBIT_COUNT_MAX + 1);
  localparam thr_set_t THR_RESET = '{dim: DIM_RESET, lock: LOCK_RESET, off: OFF_RESET};
  localparam arm_t     ARM_RESET = arm_calc(STAGE_DIM, THR_RESET, 1'b0);

  logic             advance;
  logic             held_valid;
  item_t            held;
  logic             process;
  timer_state_t     state;
  timer_state_t     state_next;
  thr_set_t         thr;
  thr_set_t         thr_next;
  logic [INH_W-1:0] inh;
  logic [INH_W-1:0] inh_next;
  result_t          result;
  result_t          result_next;

  assign advance = !result_valid || !result_stall;
  assign process = held_valid && advance;

  spit_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .command    (command),
    .lock_held  (lock_held),
    .advance    (advance),
    .held_valid (held_valid),
    .held       (held)
  );

  spit_step #(
    .INHIBIT_COUNT_MAX (INHIBIT_COUNT_MAX)
  ) u_step (
    .state       (state),
    .thr         (thr),
    .inh         (inh),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .process     (process),
    .item        (held),
    .state_next  (state_next),
    .thr_next    (thr_next),
    .inh_next    (inh_next),
    .result_next (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.stage     <= STAGE_DIM;
      state.armed     <= ARM_RESET.armed;
      state.countdown <= ARM_RESET.countdown;
      state.dim_on    <= 1'b0;
      state.power_on  <= 1'b1;
      thr             <= THR_RESET;
      inh             <= '0;
    end else begin
      state <= state_next;
      thr   <= thr_next;
      inh   <= inh_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      result <= result_next;
    end
  end

  assign stage_now     = result.stage_now;
  assign dim_active    = result.dim_active;
  assign outputs_on    = result.outputs_on;
  assign lock_request  = result.lock_request;
  assign inhibited     = result.inhibited;
  assign timer_running = result.timer_running;

endmodule
`default_nettype wire

/* sv/spit_in_stage.sv */
`default_nettype none
module spit_in_stage
  import spit_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  output logic            item_stall,
  input  wire logic [1:0] command,
  input  wire logic       lock_held,
  input  wire logic       advance,
  output logic            held_valid,
  output item_t           held
);

  logic load_en;

  // holds one transaction; frees up whenever the result stage can move
  assign load_en    = !held_valid || advance;
  assign item_stall = !load_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load_en) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en && item_valid) begin
      held.command   <= cmd_t'(command);
      held.lock_held <= lock_held;
    end
  end

endmodule
`default_nettype wire

/* sv/spit_step.sv */
`default_nettype none
module spit_step
  import spit_pkg::*;
#(
  parameter  int INHIBIT_COUNT_MAX = 255,
  localparam int INH_W             = $clog2(INHIBIT_COUNT_MAX + 1)
) (
  input  wire timer_state_t     state,
  input  wire thr_set_t         thr,
  input  wire logic [INH_W-1:0] inh,
  input  wire logic             cfg_wr_en,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [15:0]      cfg_data,
  input  wire logic             process,
  input  wire item_t            item,
  output timer_state_t          state_next,
  output thr_set_t              thr_next,
  output logic [INH_W-1:0]      inh_next,
  output result_t               result_next
);

  localparam logic [INH_W-1:0] INH_LIMIT = INH_W'(INHIBIT_COUNT_MAX);

  logic   fire_found;
  stage_t fire_stage;
  logic   do_arm;
  logic   pulse;
  thr_t   cd;
  arm_t   arm_r;

  // first enabled stage at or above the current one
  always_comb begin
    fire_found = 1'b1;
    fire_stage = STAGE_DIM;
    if (state.stage == STAGE_DIM && thr.dim != '0) begin
      fire_stage = STAGE_DIM;
    end else if (state.stage <= STAGE_LOCK && thr.lock != '0) begin
      fire_stage = STAGE_LOCK;
    end else if (state.stage <= STAGE_OFF && thr.off != '0) begin
      fire_stage = STAGE_OFF;
    end else begin
      fire_found = 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    thr_next   = thr;
    inh_next   = inh;
    do_arm     = 1'b0;
    pulse      = 1'b0;
    cd         = (state.countdown != '0) ? state.countdown - 16'd1 : '0;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_DIM: begin
          thr_next.dim = cfg_data;
          do_arm       = 1'b1;
        end
        REG_LOCK: begin
          thr_next.lock = cfg_data;
          do_arm        = 1'b1;
        end
        REG_OFF: begin
          thr_next.off = cfg_data;
          do_arm       = 1'b1;
        end
        default: ;
      endcase
    end else if (process) begin
      unique case (item.command)
        CMD_TICK: begin
          if (state.armed) begin
            state_next.countdown = cd;
            if (cd == '0) begin
              state_next.armed = 1'b0;
              if (fire_found) begin
                unique case (fire_stage)
                  STAGE_DIM:  state_next.dim_on   = 1'b1;
                  STAGE_LOCK: pulse               = !item.lock_held;
                  default:    state_next.power_on = 1'b0;
                endcase
                state_next.stage = stage_t'(fire_stage + 2'd1);
                do_arm           = 1'b1;
              end
            end
          end
        end
        CMD_ACTIVITY: begin
          // a lock is left as it is
          if (state.stage != STAGE_DIM) begin
            if (state.stage == STAGE_DONE) begin
              state_next.power_on = 1'b1;
            end
            state_next.dim_on = 1'b0;
            state_next.stage  = STAGE_DIM;
          end
          do_arm = 1'b1;
        end
        CMD_INH_ADD: begin
          if (inh < INH_LIMIT) begin
            inh_next = inh + INH_W'(1);
          end
          do_arm = 1'b1;
        end
        CMD_INH_DROP: begin
          if (inh != '0) begin
            inh_next = inh - INH_W'(1);
          end
          do_arm = 1'b1;
        end
      endcase
    end
    arm_r = arm_calc(state_next.stage, thr_next, inh_next != '0);
    if (do_arm) begin
      state_next.armed     = arm_r.armed;
      state_next.countdown = arm_r.countdown;
    end
    result_next.stage_now     = state_next.stage;
    result_next.dim_active    = state_next.dim_on;
    result_next.outputs_on    = state_next.power_on;
    result_next.lock_request  = pulse;
    result_next.inhibited     = inh_next != '0;
    result_next.timer_running = state_next.armed;
  end

endmodule
`default_nettype wire

/* sv/spit_checker.sv */
`default_nettype none
`include "assert_macros.svh"
module spit_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       result_valid,
  input wire logic       result_stall,
  input wire logic [1:0] stage_now,
  input wire logic       dim_active,
  input wire logic       outputs_on,
  input wire logic       lock_request,
  input wire logic       inhibited,
  input wire logic       timer_running
);

  logic       stalled;
  logic [6:0] payload;

  assign stalled = result_valid && result_stall;
  assign payload = {stage_now, dim_active, outputs_on, lock_request, inhibited, timer_running};

  // a stalled result keeps its payload
  `ASSERT_NEXT(a_result_hold, clk, rst, stalled, result_valid && $stable(payload))

  // a lock request only comes from the lock stage firing
  `ASSERT_IMPLY(a_lock_stage, clk, rst, result_valid && lock_request, stage_now == 2'd2)

  // displays are off exactly when all stages have been passed
  `ASSERT_IMPLY(a_power_stage, clk, rst, result_valid, (stage_now == 2'd3) == !outputs_on)

  // a live inhibitor always stops the countdown
  `ASSERT_IMPLY(a_inhibit_stop, clk, rst, result_valid && inhibited, !timer_running)

  // dim only after the first stage
  `ASSERT_IMPLY(a_dim_stage, clk, rst, result_valid && dim_active, stage_now != 2'd0)

endmodule

bind staged_idle_power_timer_core spit_checker u_spit_checker (.*);
`default_nettype wire
